@@ hdl/fnsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame number sequence repair: shared types and constants
// Result item layout, the two-wide push bundle into the result queue and the
// frame number limits for the supported disc types.
// ----------------------------------------------------------------------------
package fnsr_pkg;

  localparam int FN_W    = 18;
  localparam int TDATA_W = 24;
  localparam int TUSER_W = 2;

  typedef logic [FN_W-1:0] fnum_t;

  // Frame number limits, read as signed values.
  localparam fnum_t LIMIT_CAV = 18'd80000;
  localparam fnum_t LIMIT_PAL = 18'd105000;
  localparam fnum_t LIMIT_NTSC = 18'd121800;

  // Configuration register indexes.
  localparam logic REG_DISC_IS_CAV   = 1'b0;
  localparam logic REG_SOURCE_IS_PAL = 1'b1;

  // Result queue.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    fnum_t number;
    logic  rewrite;
    logic  drop;
    logic  last;
  } result_t;

  // Up to two results per step; slot 1 is only used together with slot 0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t d0;
    result_t d1;
  } push_t;

endpackage

@@ hdl/fnsr_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle from the repair core and
// hands them out one per cycle on the output stream while it is ready.
// ----------------------------------------------------------------------------
module fnsr_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  fnsr_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output fnsr_pkg::result_t out_data
);
  import fnsr_pkg::*;

  result_t          mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] count;
  logic             pop;
  logic [OQ_CW-1:0] n_push;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for a two-result step regardless of what leaves this cycle.
  assign room      = (count <= OQ_CW'(OQ_DEPTH - 2));
  assign n_push    = OQ_CW'(push.v0) + OQ_CW'(push.v1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.v0) begin
        mem[wr_ptr] <= push.d0;
      end
      if (push.v1) begin
        mem[wr_ptr + OQ_AW'(1)] <= push.d1;
      end
      wr_ptr <= wr_ptr + OQ_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      count <= count + n_push - OQ_CW'(pop);
    end
  end

endmodule

@@ hdl/fnsr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repair core
// Fills missing numbers, keeps the lookahead window and decides the oldest pending
// frame against its corrected predecessor, one step per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module fnsr_core #(
  parameter int D = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            disc_is_cav,
  input  logic            source_is_pal,
  input  logic            in_valid,
  input  fnsr_pkg::fnum_t in_num,
  input  logic            in_last,
  input  logic            room,
  output logic            take,
  output logic            flushing,
  output fnsr_pkg::push_t push
);
  import fnsr_pkg::*;

  localparam int CW = $clog2(D + 1);
  localparam int IW = (D > 1) ? $clog2(D) : 1;

  fnum_t         win_num [D];
  logic          win_rw  [D];
  logic [CW-1:0] seen;
  fnum_t         filled_prev;
  fnum_t         corr_prev;
  logic          held;
  fnum_t         held_num;
  logic          flush;

  fnum_t         fill_num;
  logic          fill_rw;
  logic          first_of_stream;
  logic          normal_dec;
  logic          dec_go;
  fnum_t         eff_num [D];
  logic          eff_rw  [D];
  logic [CW-1:0] dec_cnt;
  logic          dec_last;
  fnum_t         nxt;
  fnum_t         limit;
  logic          cond;
  logic          hit;
  logic          in_range;
  fnum_t         cur;
  logic          cur_rw;
  logic          cur_drop;
  fnum_t         want;

  assign flushing = flush;
  assign take     = room && !flush && in_valid;

  assign first_of_stream = !held && (seen == '0);
  assign fill_rw   = ($signed(in_num) < 18'sd1);
  assign fill_num  = fill_rw ? filled_prev + 18'd1 : in_num;
  assign normal_dec = !flush && in_valid && !first_of_stream && !in_last &&
                      (seen == CW'(D - 1));
  assign dec_go    = room && (flush || normal_dec);
  assign dec_cnt   = flush ? seen : CW'(D);
  assign dec_last  = flush && (seen == CW'(1));
  assign nxt       = corr_prev + 18'd1;
  assign want      = cur - 18'd1;
  assign limit     = disc_is_cav ? LIMIT_CAV : (source_is_pal ? LIMIT_PAL : LIMIT_NTSC);
  assign in_range  = ($signed(nxt) > 18'sd0) && ($signed(nxt) < $signed(limit));

  // In a steady-state step the newest number joins the window in the same cycle.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      eff_num[i] = win_num[i];
      eff_rw[i]  = win_rw[i];
    end
    if (normal_dec) begin
      eff_num[D-1] = fill_num;
      eff_rw[D-1]  = fill_rw;
    end
  end

  always_comb begin
    cond = (eff_num[0] != nxt) && (corr_prev != '1) && (corr_prev != eff_num[0]);
    hit  = 1'b0;
    for (int g = 1; g < D; g++) begin
      if ((CW'(g) < dec_cnt) && (corr_prev == eff_num[g] - 18'(g + 1))) begin
        hit = 1'b1;
      end
    end
    cur      = eff_num[0];
    cur_rw   = eff_rw[0];
    cur_drop = 1'b0;
    if (cond && hit) begin
      cur    = in_range ? nxt : '1;
      cur_rw = 1'b1;
    end
    if (cond && !hit && (dec_cnt >= CW'(2))) begin
      cur_drop = 1'b1;
    end
    // Unless the first frame is still held, the final frame simply follows its predecessor.
    if (dec_last && !held && (cur != nxt)) begin
      cur    = nxt;
      cur_rw = 1'b1;
    end
  end

  always_comb begin
    push = '0;
    if (dec_go) begin
      if (held) begin
        push.v0 = 1'b1;
        push.d0 = '{number: want, rewrite: (held_num != want), drop: 1'b0, last: 1'b0};
        push.v1 = 1'b1;
        push.d1 = '{number: cur, rewrite: cur_rw, drop: cur_drop, last: dec_last};
      end else begin
        push.v0 = 1'b1;
        push.d0 = '{number: cur, rewrite: cur_rw, drop: cur_drop, last: dec_last};
      end
    end else if (take && first_of_stream && in_last) begin
      push.v0 = 1'b1;
      push.d0 = '{number: in_num, rewrite: 1'b0, drop: 1'b0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= '0;
      held        <= 1'b0;
      flush       <= 1'b0;
      filled_prev <= '0;
      corr_prev   <= '0;
    end else if (dec_go) begin
      corr_prev <= cur;
      held      <= 1'b0;
      for (int i = 0; i < D - 1; i++) begin
        win_num[i] <= eff_num[i+1];
        win_rw[i]  <= eff_rw[i+1];
      end
      if (flush) begin
        seen <= seen - CW'(1);
        if (seen == CW'(1)) begin
          flush <= 1'b0;
        end
      end else begin
        filled_prev <= fill_num;
      end
    end else if (take) begin
      if (first_of_stream) begin
        if (!in_last) begin
          held        <= 1'b1;
          held_num    <= in_num;
          filled_prev <= in_num;
          corr_prev   <= in_num;
        end
      end else begin
        filled_prev                <= fill_num;
        win_num[seen[IW-1:0]]      <= fill_num;
        win_rw[seen[IW-1:0]]       <= fill_rw;
        seen                       <= seen + CW'(1);
        if (in_last) begin
          flush <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/frame_number_sequence_repair.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame number sequence repair
// Repairs a stream of decoded frame numbers: fills missing numbers, corrects
// frames that break the sequence when later frames confirm it, and flags
// frames that cannot be confirmed.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on s_axis (frame number in tdata, end of stream in tlast) and
//   results leave on m_axis (repaired number in tdata, flags in tuser, tlast
//   on the final result of a stream). cfg_we/cfg_addr/cfg_wdata write the
//   disc type registers while the block is idle.
//   An item is registered at the input, then handled by the core and placed in
//   a four-entry result queue. A frame is decided once LOOKAHEAD_DEPTH-1 later
//   frames have arrived; the first frame of a stream comes out together with
//   the second. Throughput is one item per cycle while the result queue has
//   room. On the last item of a stream the core flushes its window, one step
//   per cycle while the queue has room, and takes no new item meanwhile.
//   Reset clears all stream state and sets both registers to 1 (CAV disc).
//   When m_axis_tready is low the queue fills, the core pauses and
//   s_axis_tready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module frame_number_sequence_repair #(
  parameter int LOOKAHEAD_DEPTH = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic                           cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fnsr_pkg::TDATA_W-1:0]   s_axis_tdata,   // [17:0] frame_number
  input  logic                           s_axis_tlast,   // last_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fnsr_pkg::TDATA_W-1:0]   m_axis_tdata,   // [17:0] fixed_number
  output logic [fnsr_pkg::TUSER_W-1:0]   m_axis_tuser,   // [0] rewrite_flag, [1] delete_flag
  output logic                           m_axis_tlast    // last_out
);
  import fnsr_pkg::*;

  logic    disc_is_cav;
  logic    source_is_pal;
  logic    in_v;
  fnum_t   in_num;
  logic    in_last;
  logic    take;
  logic    flushing;
  logic    room;
  push_t   push;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_is_cav   <= 1'b1;
      source_is_pal <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DISC_IS_CAV:   disc_is_cav   <= cfg_wdata;
        REG_SOURCE_IS_PAL: source_is_pal <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !in_v || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v    <= 1'b1;
      in_num  <= s_axis_tdata[FN_W-1:0];
      in_last <= s_axis_tlast;
    end else if (take) begin
      in_v <= 1'b0;
    end
  end

  fnsr_core #(
    .D (LOOKAHEAD_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .disc_is_cav   (disc_is_cav),
    .source_is_pal (source_is_pal),
    .in_valid      (in_v),
    .in_num        (in_num),
    .in_last       (in_last),
    .room          (room),
    .take          (take),
    .flushing      (flushing),
    .push          (push)
  );

  fnsr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {{(TDATA_W - FN_W){1'b0}}, res.number};
  assign m_axis_tuser = {res.drop, res.rewrite};
  assign m_axis_tlast = res.last;

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second result pushed without the first");

  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    take |-> !flushing)
    else $error("input item taken while the window is flushing");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> room)
    else $error("result pushed into a full queue");

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> in_v)
    else $error("core took an item from an empty input register");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame number sequence repair testbench
// Streams of frame numbers are sent through the stream input under random
// idling and back-pressure. A behavioral copy of the repair rules predicts
// every result, and each result on the stream output is compared with it.
// The disc type registers are changed between streams.
// ----------------------------------------------------------------------------
module tb;
  import fnsr_pkg::*;

  localparam int WIN        = 5;
  localparam int STALL_MAX  = 3000;
  localparam int HOLD_LEN   = 150;
  localparam fnum_t ALL_ONES = '1;

  typedef struct {
    fnum_t number;
    logic  last;
    bit    settle_first;  // wait for every expected result before sending
  } frame_in_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [TUSER_W-1:0] m_tuser;
  logic m_tlast;

  frame_in_t frames_to_send[$];
  result_t   repairs_due[$];
  int n_queued = 0;
  int n_taken = 0;
  int fails = 0;
  int stall_cycles = 0;
  logic in_took = 1'b0;
  int hold_left = 0;
  bit hold_done = 0;
  bit calm;

  // Behavioral state of the repair logic.
  logic  cav_mode = 1'b1;
  logic  pal_mode = 1'b1;
  fnum_t fill_prev, corr_prev, head_num;
  logic  head_held;
  fnum_t look_num [WIN];
  logic  look_rw [WIN];
  int    look_cnt;

  frame_number_sequence_repair dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata),
    .s_axis_tlast(s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .m_axis_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // No idling on either side during this stretch of the stream.
  assign calm = (n_taken >= 300) && (n_taken < 380);

  function automatic fnum_t frame_limit_now();
    if (cav_mode) return LIMIT_CAV;
    return pal_mode ? LIMIT_PAL : LIMIT_NTSC;
  endfunction

  function automatic void clear_stream();
    fill_prev = '0;
    corr_prev = '0;
    head_held = 1'b0;
    head_num = '0;
    look_cnt = 0;
    for (int i = 0; i < WIN; i++) begin
      look_num[i] = '0;
      look_rw[i] = 1'b0;
    end
  endfunction

  function automatic void push_repair(fnum_t n, logic rw, logic del, logic last);
    result_t r;
    r.number = n;
    r.rewrite = rw;
    r.drop = del;
    r.last = last;
    repairs_due.push_back(r);
  endfunction

  // Decides the oldest frame in the window, searching gaps 1 .. span-1.
  function automatic void settle_oldest(int span, bit at_end);
    fnum_t cur;
    fnum_t nxt;
    fnum_t want;
    logic  rw;
    logic  del;
    bit    hit;
    cur = look_num[0];
    rw = look_rw[0];
    del = 1'b0;
    hit = 0;
    nxt = corr_prev + 1'b1;
    if (span > WIN) span = WIN;
    if (cur != nxt && corr_prev != ALL_ONES && corr_prev != cur) begin
      for (int g = 1; g < span; g++) begin
        if (!hit && corr_prev == fnum_t'(look_num[g] - fnum_t'(g + 1))) begin
          cur = ($signed(nxt) > 0 && $signed(nxt) < $signed(frame_limit_now())) ?
                nxt : ALL_ONES;
          rw = 1'b1;
          hit = 1;
        end
      end
      if (!hit && span >= 2) del = 1'b1;
    end
    if (at_end && !head_held && cur != nxt) begin
      cur = nxt;
      rw = 1'b1;
    end
    corr_prev = cur;
    if (head_held) begin
      want = cur - 1'b1;
      push_repair(want, head_num != want, 1'b0, 1'b0);
      head_held = 1'b0;
    end
    push_repair(cur, rw, del, at_end);
    for (int i = 0; i < WIN - 1; i++) begin
      look_num[i] = look_num[i + 1];
      look_rw[i] = look_rw[i + 1];
    end
    look_num[WIN-1] = '0;
    look_rw[WIN-1] = 1'b0;
    if (look_cnt > 0) look_cnt--;
  endfunction

  function automatic void repair_frame(fnum_t raw, logic last);
    fnum_t v;
    logic  rw;
    if (!head_held && look_cnt == 0) begin
      // The first frame of a stream is held until its successor decides it.
      fill_prev = raw;
      corr_prev = raw;
      if (last) begin
        push_repair(raw, 1'b0, 1'b0, 1'b1);
        clear_stream();
      end else begin
        head_held = 1'b1;
        head_num = raw;
      end
    end else begin
      if ($signed(raw) < 1) begin
        v = fill_prev + 1'b1;
        rw = 1'b1;
      end else begin
        v = raw;
        rw = 1'b0;
      end
      fill_prev = v;
      if (look_cnt >= WIN) look_cnt = WIN - 1;
      look_num[look_cnt] = v;
      look_rw[look_cnt] = rw;
      look_cnt++;
      if (!last) begin
        if (look_cnt >= WIN) settle_oldest(WIN, 0);
      end else begin
        while (look_cnt > 0) settle_oldest(look_cnt < WIN ? look_cnt : WIN, look_cnt == 1);
        clear_stream();
      end
    end
  endfunction

  // Input driver.
  always @(negedge clk) begin
    frame_in_t it;
    if (!rst && (!s_tvalid || in_took)) begin
      if (frames_to_send.size() > 0 &&
          !(frames_to_send[0].settle_first && repairs_due.size() > 0) &&
          (calm || $urandom_range(99) >= 18)) begin
        it = frames_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_W-FN_W){1'b0}}, it.number};
        s_tlast <= it.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once the stream is well under way.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_taken >= 120) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Acceptance, prediction, checking and the watchdog.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_took <= 1'b0;
      cav_mode = 1'b1;
      pal_mode = 1'b1;
      clear_stream();
    end else begin
      in_took <= s_tvalid && s_tready;
      if (cfg_we) begin
        if (cfg_addr == REG_DISC_IS_CAV) cav_mode = cfg_wdata;
        else pal_mode = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        repair_frame(s_tdata[FN_W-1:0], s_tlast);
        n_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (repairs_due.size() == 0) begin
          $error("unexpected result: fixed_number %0d", $signed(m_tdata[FN_W-1:0]));
          fails++;
        end else begin
          want = repairs_due.pop_front();
          if (m_tdata[FN_W-1:0] != want.number) begin
            $error("fixed_number: expected %0d, got %0d",
                   $signed(want.number), $signed(m_tdata[FN_W-1:0]));
            fails++;
          end
          if (m_tuser[0] != want.rewrite) begin
            $error("rewrite_flag: expected %0b, got %0b", want.rewrite, m_tuser[0]);
            fails++;
          end
          if (m_tuser[1] != want.drop) begin
            $error("delete_flag: expected %0b, got %0b", want.drop, m_tuser[1]);
            fails++;
          end
          if (m_tlast != want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, m_tlast);
            fails++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic queue_frame(int n, bit last, bit settle);
    frame_in_t it;
    it.number = fnum_t'(n);
    it.last = last;
    it.settle_first = settle;
    frames_to_send.push_back(it);
    n_queued++;
  endtask

  task automatic write_reg(logic idx, logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
  endtask

  // A mostly counting stream with missing, glitched, repeated and random frames.
  task automatic queue_stream(int len, bit settle);
    int base;
    int pick;
    int v;
    case ($urandom_range(4))
      0: base = 80000 - $urandom_range(30, 1);
      1: base = 105000 - $urandom_range(30, 1);
      2: base = 121800 - $urandom_range(30, 1);
      3: base = 131071 - $urandom_range(30, 0);
      default: base = $urandom_range(125000, 1);
    endcase
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) v = base + i;
      else if (pick < 78) v = $urandom_range(1) ? 0 : -int'($urandom_range(131072, 1));
      else if (pick < 88) v = base + i + int'($urandom_range(40)) - 20;
      else if (pick < 93) v = base + i - 1;
      else v = int'($urandom_range(262143));
      queue_frame(v, i == len - 1, settle && i == 0);
    end
  endtask

  initial begin
    logic cav;
    logic pal;
    int cnt;
    int len;
    bit settled;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin cav = 1'b1; pal = 1'b1; end
        1: begin cav = 1'b0; pal = 1'b1; end
        2: begin cav = 1'b0; pal = 1'b0; end
        3: begin cav = 1'b1; pal = 1'b0; end
        default: begin cav = 1'($urandom_range(1)); pal = 1'($urandom_range(1)); end
      endcase
      write_reg(REG_DISC_IS_CAV, cav);
      write_reg(REG_SOURCE_IS_PAL, pal);
      @(negedge clk);
      cfg_we <= 1'b0;
      if (ph == 0) begin
        // Single frame, two frames, then fills, corrections, repeats and edges.
        queue_frame(-1, 1, 0);
        queue_frame(0, 0, 0);
        queue_frame(131071, 1, 0);
        queue_frame(100, 0, 0);
        queue_frame(101, 0, 0);
        queue_frame(0, 0, 0);
        queue_frame(103, 0, 0);
        queue_frame(500, 0, 0);
        queue_frame(105, 0, 0);
        queue_frame(106, 0, 0);
        queue_frame(106, 0, 0);
        queue_frame(-131072, 0, 0);
        queue_frame(108, 0, 0);
        queue_frame(109, 0, 0);
        queue_frame(50, 1, 0);
        // A correction past the limit becomes -1, and the next frame is then left as it is.
        queue_frame(79998, 0, 0);
        queue_frame(79999, 0, 0);
        queue_frame(7, 0, 0);
        queue_frame(80001, 0, 0);
        queue_frame(80002, 0, 0);
        queue_frame(131071, 0, 0);
        queue_frame(3, 1, 0);
      end else begin
        cnt = 0;
        settled = 0;
        while (cnt < 50) begin
          len = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : $urandom_range(30, 4);
          queue_stream(len, !settled && cnt >= 30);
          if (cnt >= 30) settled = 1;
          cnt += len;
        end
      end
      while (n_taken != n_queued || repairs_due.size() != 0) @(negedge clk);
      repeat (16) @(negedge clk);
    end
    if (fails == 0 && repairs_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
